@@ src/teiq_pkg.sv @@
// Shared types and constants for the timed event interrupt queue.
package teiq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ENTRY_W = 67;

  localparam logic [1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_IDLE     = 2'd2;

  localparam logic [1:0] RES_FIRED    = 2'd0;
  localparam logic [1:0] RES_DONE     = 2'd1;
  localparam logic [1:0] RES_HALT     = 2'd2;
  localparam logic [1:0] RES_REJECT   = 2'd3;

  localparam logic [2:0] KIND_TIMER   = 3'd0;
  localparam logic [2:0] KIND_MAX     = 3'd5;

  localparam logic CFG_SYS_TICK  = 1'b0;
  localparam logic CFG_USER_TICK = 1'b1;

  localparam logic [15:0] SYS_TICK_RST  = 16'd10;
  localparam logic [15:0] USER_TICK_RST = 16'd1;

  typedef struct packed {
    logic [1:0]  command;
    logic [30:0] delay;
    logic [2:0]  event_kind;
    logic [31:0] event_arg;
    logic        user_mode;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  fired_kind;
    logic [31:0] fired_arg;
    logic [31:0] fired_time;
    logic [31:0] total_ticks_out;
    logic [31:0] idle_ticks_out;
    logic [4:0]  queue_count_out;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] due;
    logic [2:0]  kind;
    logic [31:0] arg;
  } entry_t;

endpackage

@@ src/teiq_mem.sv @@
// Event store: one write port, one registered read port.
module teiq_mem #(
  parameter int unsigned DEPTH = teiq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  teiq_pkg::entry_t    wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output teiq_pkg::entry_t    rdata
);

  teiq_pkg::entry_t mem [DEPTH];
  teiq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/timed_event_interrupt_queue.sv @@
// Top level: time-sorted event queue with tick counters.
//
// Input channel in_valid/in_stall/in_data carries one command per transaction:
// schedule, tick or idle. The result channel out_valid/out_stall/out_data
// returns one or more results per command; the final one has last set.
// Events live in a circular buffer in a single-port-read memory; the head
// pointer moves as events fire. Schedule: a reject goes straight to the
// final result; else the sorted insert shifts each entry due later than the
// new one toward the tail and writes the new entry behind those that stay
// ahead. Tick and idle return one fired result per event that fires, then
// the final result.
// One command is worked on at a time; in_stall is high until the final
// result is registered. A stalled receiver freezes the output register and
// the sequencer waits on it. Reset (rst_n low, synchronous) empties the
// queue, clears all tick counters and loads the default tick amounts;
// the memory contents need no clearing. cfg_we writes a tick amount.
module timed_event_interrupt_queue #(
  parameter int unsigned QUEUE_DEPTH = teiq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  teiq_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output teiq_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic            cfg_addr,
  input  logic [15:0]     cfg_wdata
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_RD, S_INS_CMP, S_HRD, S_HCHK, S_IDL1, S_IDL2, S_FIN
  } state_t;

  state_t            state_r;
  logic [15:0]       sys_amt_r, user_amt_r;
  logic [31:0]       total_r, sys_r, user_r, idle_r;
  logic [CW-1:0]     count_r, idx_r;
  logic [AW-1:0]     head_r;
  logic              idle_mode_r;
  logic [1:0]        fin_kind_r;
  teiq_pkg::entry_t  new_r;
  logic              out_valid_r;
  teiq_pkg::out_t    out_r;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  teiq_pkg::entry_t  mem_wdata, rdata;
  logic              out_free, accept;
  logic [15:0]       amt;
  logic [AW-1:0]     head_inc;
  logic              lone_timer, due_now;
  logic              out_load, out_valid_nxt;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [AW+CW:0] s;
    s = (AW+CW+1)'(h) + (AW+CW+1)'(i);
    if (s >= (AW+CW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+CW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign out_free   = !out_valid_r || !out_stall;
  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign amt        = in_data.user_mode ? user_amt_r : sys_amt_r;
  assign head_inc   = phys(head_r, CW'(1));
  assign lone_timer = (count_r == CW'(1)) && (rdata.kind == teiq_pkg::KIND_TIMER);
  assign due_now    = (rdata.due <= total_r);

  assign out_load = out_free &&
                    (((state_r == S_HCHK) && due_now && !(idle_mode_r && lone_timer)) ||
                     ((state_r == S_IDL2) && !lone_timer) ||
                     (state_r == S_FIN));
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = phys(head_r, idx_r);
    mem_raddr = head_r;
    mem_wdata = new_r;
    case (state_r)
      S_IDLE: begin
        mem_re = accept && (in_data.command == teiq_pkg::CMD_IDLE) && (count_r != '0);
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = phys(head_r, idx_r - CW'(1));
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rdata.due > new_r.due) begin
          mem_wdata = rdata;
        end
      end
      S_HRD: begin
        mem_re = (count_r != '0);
      end
      default: ;
    endcase
  end

  teiq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sys_amt_r   <= teiq_pkg::SYS_TICK_RST;
      user_amt_r  <= teiq_pkg::USER_TICK_RST;
      total_r     <= '0;
      sys_r       <= '0;
      user_r      <= '0;
      idle_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      head_r      <= '0;
      idle_mode_r <= 1'b0;
      fin_kind_r  <= teiq_pkg::RES_DONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_addr == teiq_pkg::CFG_SYS_TICK) begin
          sys_amt_r <= cfg_wdata;
        end else begin
          user_amt_r <= cfg_wdata;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_data.command)
              teiq_pkg::CMD_SCHEDULE: begin
                new_r.due  <= total_r + {1'b0, in_data.delay};
                new_r.kind <= in_data.event_kind;
                new_r.arg  <= in_data.event_arg;
                idx_r      <= count_r;
                if (in_data.delay == '0 || in_data.event_kind > teiq_pkg::KIND_MAX ||
                    count_r >= CW'(QUEUE_DEPTH)) begin
                  fin_kind_r <= teiq_pkg::RES_REJECT;
                  state_r    <= S_FIN;
                end else begin
                  state_r <= S_INS_RD;
                end
              end
              teiq_pkg::CMD_TICK: begin
                total_r     <= total_r + {16'd0, amt};
                if (in_data.user_mode) begin
                  user_r <= user_r + {16'd0, amt};
                end else begin
                  sys_r <= sys_r + {16'd0, amt};
                end
                idle_mode_r <= 1'b0;
                state_r     <= S_HRD;
              end
              teiq_pkg::CMD_IDLE: begin
                idle_mode_r <= 1'b1;
                if (count_r == '0) begin
                  fin_kind_r <= teiq_pkg::RES_HALT;
                  state_r    <= S_FIN;
                end else begin
                  state_r <= S_IDL1;
                end
              end
              default: begin
                fin_kind_r <= teiq_pkg::RES_REJECT;
                state_r    <= S_FIN;
              end
            endcase
          end
        end
        S_INS_RD: begin
          if (idx_r == '0) begin
            count_r    <= count_r + CW'(1);
            fin_kind_r <= teiq_pkg::RES_DONE;
            state_r    <= S_FIN;
          end else begin
            state_r <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rdata.due > new_r.due) begin
            idx_r   <= idx_r - CW'(1);
            state_r <= S_INS_RD;
          end else begin
            count_r    <= count_r + CW'(1);
            fin_kind_r <= teiq_pkg::RES_DONE;
            state_r    <= S_FIN;
          end
        end
        S_HRD: begin
          if (count_r == '0) begin
            fin_kind_r <= teiq_pkg::RES_DONE;
            state_r    <= S_FIN;
          end else begin
            state_r <= S_HCHK;
          end
        end
        S_HCHK: begin
          if (!due_now || (idle_mode_r && lone_timer)) begin
            fin_kind_r <= teiq_pkg::RES_DONE;
            state_r    <= S_FIN;
          end else if (out_free) begin
            out_r       <= '{teiq_pkg::RES_FIRED, rdata.kind, rdata.arg, rdata.due,
                             total_r, idle_r, 5'(count_r - CW'(1)), 1'b0};
            head_r      <= head_inc;
            count_r     <= count_r - CW'(1);
            state_r     <= S_HRD;
          end
        end
        S_IDL1: begin
          if (!due_now) begin
            idle_r  <= idle_r + (rdata.due - total_r);
            total_r <= rdata.due;
          end
          state_r <= S_IDL2;
        end
        S_IDL2: begin
          if (lone_timer) begin
            fin_kind_r <= teiq_pkg::RES_HALT;
            state_r    <= S_FIN;
          end else if (out_free) begin
            out_r       <= '{teiq_pkg::RES_FIRED, rdata.kind, rdata.arg, rdata.due,
                             total_r, idle_r, 5'(count_r - CW'(1)), 1'b0};
            head_r      <= head_inc;
            count_r     <= count_r - CW'(1);
            state_r     <= S_HRD;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_r       <= '{fin_kind_r, 3'd0, 32'd0, 32'd0, total_r, idle_r,
                             5'(count_r), 1'b1};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ src/teiq_checker.sv @@
// Port-level assertions for the event queue, bound to the top level.
module teiq_checker #(
  parameter int unsigned QUEUE_DEPTH = teiq_pkg::QUEUE_DEPTH_DEF
) (
  input logic            clk,
  input logic            rst_n,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input teiq_pkg::out_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input taken while a command is still producing results");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind != teiq_pkg::RES_FIRED |->
      out_data.fired_arg == '0 && out_data.fired_time == '0 && out_data.fired_kind == '0)
    else $error("event fields set on a non-fired result");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.queue_count_out) <= QUEUE_DEPTH)
    else $error("queue count beyond depth");

endmodule

bind timed_event_interrupt_queue teiq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_teiq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
